/* src/pemb_pkg.sv */
package pemb_pkg;

	localparam int AtomW  = 6;
	localparam int CountW = 7;
	localparam int MaskW  = 64;
	localparam int QDepth = 2;

	localparam int MinAtomsBeyond = 5;
	localparam int MinAtoms14     = 4;
	localparam int MinAtoms13     = 3;

	typedef enum logic [1:0] {
		FUNC_ANGLE    = 2'd0,
		FUNC_DIHEDRAL = 2'd1,
		FUNC_QUERY    = 2'd2,
		FUNC_CLEAR    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_BEYOND = 2'd0,
		MODE_14     = 2'd1,
		MODE_13     = 2'd2,
		MODE_ALL    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	localparam logic CFG_PAIR_MODE  = 1'b0;
	localparam logic CFG_ATOM_COUNT = 1'b1;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		func_t            func;
		logic [AtomW-1:0] a;
		logic [AtomW-1:0] b;
		logic [AtomW-1:0] c;
		logic [AtomW-1:0] d;
		logic             range_err;
	} cmd_t;

	function automatic logic [MaskW-1:0] atom_bit(input logic [AtomW-1:0] idx);
		atom_bit = MaskW'(1) << idx;
	endfunction

	// Bits strictly above the given atom.
	function automatic logic [MaskW-1:0] above_mask(input logic [AtomW-1:0] idx);
		above_mask = ({MaskW{1'b1}} << idx) << 1;
	endfunction

endpackage

/* src/pemb_req_if.sv */
interface pemb_req_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              func;
	logic [pemb_pkg::AtomW-1:0] atom_a;
	logic [pemb_pkg::AtomW-1:0] atom_b;
	logic [pemb_pkg::AtomW-1:0] atom_c;
	logic [pemb_pkg::AtomW-1:0] atom_d;

	modport source (output valid, func, atom_a, atom_b, atom_c, atom_d, input ready);
	modport sink (input valid, func, atom_a, atom_b, atom_c, atom_d, output ready);
endinterface

/* src/pemb_rsp_if.sv */
interface pemb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [pemb_pkg::AtomW-1:0] query_atom;
	logic [pemb_pkg::MaskW-1:0] partner_mask;
	logic [1:0]                 status;

	modport source (output valid, query_atom, partner_mask, status, input ready);
	modport sink (input valid, query_atom, partner_mask, status, output ready);
endinterface

/* src/pemb_ram.sv */
module pemb_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/pemb_front.sv */
module pemb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	pemb_req_if.sink                    req,
	input  logic [pemb_pkg::CountW-1:0] n_eff,
	output pemb_pkg::cmd_t              cmd,
	output logic                        cmd_valid,
	input  logic                        cmd_pop
);

	localparam int PtrW = (pemb_pkg::QDepth > 1) ? $clog2(pemb_pkg::QDepth) : 1;
	localparam int CntW = $clog2(pemb_pkg::QDepth + 1);

	pemb_pkg::cmd_t  ent_q [pemb_pkg::QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	pemb_pkg::cmd_t  cls;
	logic            push;
	logic            a_bad, b_bad, c_bad, d_bad;

	// An index is out of range when it reaches the effective atom count.
	assign a_bad = {1'b0, req.atom_a} >= n_eff;
	assign b_bad = {1'b0, req.atom_b} >= n_eff;
	assign c_bad = {1'b0, req.atom_c} >= n_eff;
	assign d_bad = {1'b0, req.atom_d} >= n_eff;

	always_comb begin
		cls.func = pemb_pkg::func_t'(req.func);
		cls.a    = req.atom_a;
		cls.b    = req.atom_b;
		cls.c    = req.atom_c;
		cls.d    = req.atom_d;
		unique case (pemb_pkg::func_t'(req.func))
			pemb_pkg::FUNC_ANGLE:    cls.range_err = a_bad | b_bad | c_bad;
			pemb_pkg::FUNC_DIHEDRAL: cls.range_err = a_bad | b_bad | c_bad | d_bad;
			pemb_pkg::FUNC_QUERY:    cls.range_err = a_bad;
			default:                 cls.range_err = 1'b0;
		endcase
	end

	assign req.ready = cnt_q != CntW'(pemb_pkg::QDepth);
	assign push      = req.valid & req.ready;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(pemb_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(pemb_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(push) - CntW'(cmd_pop);
		end
	end

endmodule

/* src/pemb_back.sv */
module pemb_back #(
	parameter int MAX_ANGLES    = 128,
	parameter int MAX_DIHEDRALS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pemb_pkg::cmd_t              cmd,
	input  logic                        cmd_valid,
	output logic                        cmd_pop,
	input  pemb_pkg::mode_t             pair_mode,
	input  logic [pemb_pkg::CountW-1:0] n_eff,
	pemb_rsp_if.source                  rsp
);

	localparam int AW   = pemb_pkg::AtomW;
	localparam int MW   = pemb_pkg::MaskW;
	localparam int AAW  = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
	localparam int DAW  = (MAX_DIHEDRALS > 1) ? $clog2(MAX_DIHEDRALS) : 1;
	localparam int AFW  = $clog2(MAX_ANGLES + 1);
	localparam int DFW  = $clog2(MAX_DIHEDRALS + 1);
	localparam int IW   = (AFW > DFW) ? AFW : DFW;
	localparam int ARW  = 3 * AW;
	localparam int DRW  = 4 * AW;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ANG  = 4'b0010,
		ST_DIH  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t         state_q;
	logic [AFW-1:0] ang_fill_q;
	logic [DFW-1:0] dih_fill_q;
	logic [IW-1:0]  idx_q;
	logic           ang_rd_s1, dih_rd_s1;
	logic           scan_ang_q, scan_dih_q;
	logic [AW-1:0]  qi_q;
	logic [MW-1:0]  mask_q;
	pemb_pkg::status_t qstat_q;

	logic           out_vld_q;
	logic [AW-1:0]  out_atom_q;
	logic [MW-1:0]  out_mask_q;
	logic [1:0]     out_stat_q;

	logic           out_free;
	logic           out_set;
	logic           ang_full, dih_full;
	logic           ang_we, dih_we, ang_re, dih_re;
	logic [ARW-1:0] ang_rdata;
	logic [DRW-1:0] dih_rdata;
	logic [MW-1:0]  mask_nx;
	logic [MW-1:0]  span_mask;
	logic           too_few;
	logic [AW-1:0]  ra0, ra1, ra2, rd0, rd1, rd2, rd3;
	pemb_pkg::status_t load_stat;

	assign out_free = !out_vld_q || rsp.ready;
	assign ang_full = ang_fill_q == AFW'(MAX_ANGLES);
	assign dih_full = dih_fill_q == DFW'(MAX_DIHEDRALS);

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid &&
		((cmd.func == pemb_pkg::FUNC_QUERY) || out_free);

	// A result is loaded either for a load or clear, or when a finished scan can leave.
	assign out_set = (cmd_pop && cmd.func != pemb_pkg::FUNC_QUERY) ||
		(state_q == ST_DONE && !ang_rd_s1 && !dih_rd_s1 && out_free);

	assign ang_we = cmd_pop && (cmd.func == pemb_pkg::FUNC_ANGLE) && !cmd.range_err && !ang_full;
	assign dih_we = cmd_pop && (cmd.func == pemb_pkg::FUNC_DIHEDRAL) && !cmd.range_err &&
		!dih_full;
	assign ang_re = (state_q == ST_ANG) && scan_ang_q && (idx_q < IW'(ang_fill_q));
	assign dih_re = (state_q == ST_DIH) && scan_dih_q && (idx_q < IW'(dih_fill_q));

	pemb_ram #(.WIDTH(ARW), .DEPTH(MAX_ANGLES)) u_ang_ram (
		.clk   (clk),
		.we    (ang_we),
		.waddr (ang_fill_q[AAW-1:0]),
		.wdata ({cmd.a, cmd.b, cmd.c}),
		.re    (ang_re),
		.raddr (idx_q[AAW-1:0]),
		.rdata (ang_rdata)
	);

	pemb_ram #(.WIDTH(DRW), .DEPTH(MAX_DIHEDRALS)) u_dih_ram (
		.clk   (clk),
		.we    (dih_we),
		.waddr (dih_fill_q[DAW-1:0]),
		.wdata ({cmd.a, cmd.b, cmd.c, cmd.d}),
		.re    (dih_re),
		.raddr (idx_q[DAW-1:0]),
		.rdata (dih_rdata)
	);

	assign {ra0, ra1, ra2}      = ang_rdata;
	assign {rd0, rd1, rd2, rd3} = dih_rdata;

	// Fold the entry read in the previous cycle into the running mask.
	always_comb begin
		mask_nx = mask_q;
		if (ang_rd_s1) begin
			if (pair_mode == pemb_pkg::MODE_BEYOND) begin
				if (ra0 == qi_q || ra1 == qi_q || ra2 == qi_q) begin
					mask_nx = mask_nx & ~(pemb_pkg::atom_bit(ra0) | pemb_pkg::atom_bit(ra1) |
						pemb_pkg::atom_bit(ra2));
				end
			end else if (ra0 == qi_q || ra2 == qi_q) begin
				mask_nx = mask_nx | pemb_pkg::atom_bit(ra0) | pemb_pkg::atom_bit(ra2);
			end
		end
		if (dih_rd_s1) begin
			if (pair_mode == pemb_pkg::MODE_BEYOND) begin
				if (rd0 == qi_q || rd1 == qi_q || rd2 == qi_q || rd3 == qi_q) begin
					mask_nx = mask_nx & ~(pemb_pkg::atom_bit(rd0) | pemb_pkg::atom_bit(rd1) |
						pemb_pkg::atom_bit(rd2) | pemb_pkg::atom_bit(rd3));
				end
			end else if (rd0 == qi_q || rd3 == qi_q) begin
				mask_nx = mask_nx | pemb_pkg::atom_bit(rd0) | pemb_pkg::atom_bit(rd3);
			end
		end
	end

	assign span_mask = (n_eff >= pemb_pkg::CountW'(MW)) ? {MW{1'b1}} :
		((MW'(1) << n_eff[AW-1:0]) - MW'(1));

	always_comb begin
		unique case (pair_mode)
			pemb_pkg::MODE_BEYOND: too_few = n_eff < pemb_pkg::CountW'(pemb_pkg::MinAtomsBeyond);
			pemb_pkg::MODE_14:     too_few = n_eff < pemb_pkg::CountW'(pemb_pkg::MinAtoms14);
			pemb_pkg::MODE_13:     too_few = n_eff < pemb_pkg::CountW'(pemb_pkg::MinAtoms13);
			default:               too_few = 1'b0;
		endcase
	end

	always_comb begin
		priority if (cmd.range_err) begin
			load_stat = pemb_pkg::STAT_RANGE;
		end else if ((cmd.func == pemb_pkg::FUNC_ANGLE && ang_full) ||
				(cmd.func == pemb_pkg::FUNC_DIHEDRAL && dih_full)) begin
			load_stat = pemb_pkg::STAT_FULL;
		end else begin
			load_stat = pemb_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.func == pemb_pkg::FUNC_QUERY) begin
			qi_q    <= cmd.a;
			qstat_q <= cmd.range_err ? pemb_pkg::STAT_RANGE : pemb_pkg::STAT_OK;
			if (cmd.range_err || too_few) begin
				mask_q <= '0;
			end else if (pair_mode == pemb_pkg::MODE_BEYOND || pair_mode == pemb_pkg::MODE_ALL) begin
				mask_q <= {MW{1'b1}};
			end else begin
				mask_q <= '0;
			end
		end else begin
			mask_q <= mask_nx;
		end
		if (cmd_pop && cmd.func != pemb_pkg::FUNC_QUERY) begin
			out_atom_q <= cmd.a;
			out_mask_q <= '0;
			out_stat_q <= load_stat;
		end else if (state_q == ST_DONE && !ang_rd_s1 && !dih_rd_s1 && out_free) begin
			out_atom_q <= qi_q;
			out_mask_q <= mask_q & span_mask & pemb_pkg::above_mask(qi_q);
			out_stat_q <= qstat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ang_fill_q <= '0;
			dih_fill_q <= '0;
			idx_q      <= '0;
			ang_rd_s1  <= 1'b0;
			dih_rd_s1  <= 1'b0;
			scan_ang_q <= 1'b0;
			scan_dih_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			ang_rd_s1 <= ang_re;
			dih_rd_s1 <= dih_re;
			if (out_set) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ang_we) begin
				ang_fill_q <= ang_fill_q + 1'b1;
			end
			if (dih_we) begin
				dih_fill_q <= dih_fill_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.func == pemb_pkg::FUNC_QUERY) begin
							idx_q      <= '0;
							scan_ang_q <= !cmd.range_err && !too_few &&
								(pair_mode == pemb_pkg::MODE_BEYOND ||
								pair_mode == pemb_pkg::MODE_13);
							scan_dih_q <= !cmd.range_err && !too_few &&
								(pair_mode == pemb_pkg::MODE_BEYOND ||
								pair_mode == pemb_pkg::MODE_14);
							state_q    <= ST_ANG;
						end else if (cmd.func == pemb_pkg::FUNC_CLEAR) begin
							ang_fill_q <= '0;
							dih_fill_q <= '0;
						end
					end
				end
				ST_ANG: begin
					if (ang_re) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q   <= '0;
						state_q <= ST_DIH;
					end
				end
				ST_DIH: begin
					if (dih_re) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Wait for the last read to be folded in before the result goes out.
					if (!ang_rd_s1 && !dih_rd_s1 && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.query_atom   = out_atom_q;
	assign rsp.partner_mask = out_mask_q;
	assign rsp.status       = out_stat_q;

endmodule

/* src/pair_exclusion_mask_builder_core.sv */
// Pair exclusion mask builder. Angle and dihedral records are appended to two table
// memories; a query transaction returns a 64-bit mask of partner atoms above the queried
// atom, chosen by pair_mode. Every transaction on req yields exactly one transaction on rsp.
// Loads and clears are answered without a scan. A query walks the stored angle entries
// and then the stored dihedral entries through the single read port of each table, one
// entry per cycle, in mode 0, only the matching single table in modes 1 and 2, and no
// table at all in mode 3 or when the mask is empty
// up front. A two-entry command queue keeps req open while the scan runs and a result
// waits on rsp. Configuration may be written only when no transaction is in flight.
module pair_exclusion_mask_builder_core #(
	parameter int MAX_ATOMS     = 64,
	parameter int MAX_ANGLES    = 128,
	parameter int MAX_DIHEDRALS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pemb_req_if.sink                    req,
	pemb_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [pemb_pkg::CountW-1:0] cfg_data
);

	pemb_pkg::mode_t             pair_mode_q;
	logic [pemb_pkg::CountW-1:0] atom_count_q;
	logic [pemb_pkg::CountW-1:0] n_eff;
	pemb_pkg::cmd_t              cmd;
	logic                        cmd_valid;
	logic                        cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mode_q  <= pemb_pkg::MODE_BEYOND;
			atom_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pemb_pkg::CFG_PAIR_MODE:  pair_mode_q  <= pemb_pkg::mode_t'(cfg_data[1:0]);
				pemb_pkg::CFG_ATOM_COUNT: atom_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff = (atom_count_q > pemb_pkg::CountW'(MAX_ATOMS)) ?
		pemb_pkg::CountW'(MAX_ATOMS) : atom_count_q;

	pemb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.n_eff     (n_eff),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	pemb_back #(
		.MAX_ANGLES    (MAX_ANGLES),
		.MAX_DIHEDRALS (MAX_DIHEDRALS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.pair_mode (pair_mode_q),
		.n_eff     (n_eff),
		.rsp       (rsp)
	);

	a_err_empty_mask: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != pemb_pkg::STAT_OK |-> rsp.partner_mask == '0)
		else $error("error status with a non-empty partner mask");

	a_no_rsvd_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status != pemb_pkg::STAT_RSVD)
		else $error("reserved status code on response");

	a_mask_above_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.partner_mask & ~pemb_pkg::above_mask(rsp.query_atom)) == '0)
		else $error("partner mask has a bit at or below the queried atom");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command queue popped while empty");

endmodule
